/* hw/rtl/bfa_pkg.sv */
// bfa_pkg: shared constants, status codes and the controller/datapath
// command and status bundles of the buddy frame allocator.
// No dependencies.
`default_nettype none

package bfa_pkg;

  localparam int FRAMES = 64;
  localparam int ORDERS = 7;
  localparam int SPAN   = 1 << (ORDERS - 1);
  localparam int OW     = $clog2(ORDERS);
  localparam int FW     = $clog2(SPAN);
  localparam int CW     = FW + 1;
  localparam int AW     = OW + FW;
  localparam int IDW    = 16;
  localparam int SZW    = 7;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD      = 2'd2
  } status_t;

  typedef struct packed {
    logic    load;
    logic    front_rd;
    logic    take_front;
    logic    sh_rd;
    logic    sh_wr;
    logic    sh_end;
    logic    split;
    logic    scan_rd;
    logic    scan_next;
    logic    merge;
    logic    push;
    logic    free_clear;
    logic    alloc_fin;
    logic    result;
    status_t code;
  } cmd_t;

  typedef struct packed {
    logic req_free;
    logic bad;
    logic no_space;
    logic not_owned;
    logic o_gt_ord;
    logic shift_last;
    logic scan_end;
    logic match;
    logic top;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/bfa_ram.sv */
// bfa_ram: generic simple dual-port ram, one write and one registered read.
// No dependencies.
`default_nettype none

module bfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/bfa_datapath.sv */
// bfa_datapath: request registers, free list ram and counts, owned map,
// id counter and result register. Uses bfa_pkg and bfa_ram.
`default_nettype none

module bfa_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_type,
  input  logic [bfa_pkg::SZW-1:0]    block_size,
  input  logic [bfa_pkg::FW-1:0]     free_start,
  input  logic                       has_prior_id,
  input  logic [bfa_pkg::IDW-1:0]    prior_id,
  input  bfa_pkg::cmd_t              cmd,
  output bfa_pkg::sts_t              sts,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [bfa_pkg::FW-1:0]     start_frame,
  output logic [bfa_pkg::OW-1:0]     block_order,
  output logic [bfa_pkg::IDW-1:0]    alloc_id,
  output logic [1:0]                 status
);

  localparam logic [bfa_pkg::OW-1:0] TOP = bfa_pkg::OW'(bfa_pkg::ORDERS - 1);

  logic                    req_free, bad_q, prior_en;
  logic [bfa_pkg::IDW-1:0] prior_q, id_q, next_id;
  logic [bfa_pkg::OW-1:0]  ord_q, o, on, fo;
  logic [bfa_pkg::FW-1:0]  s, mask, buddy;
  logic [bfa_pkg::CW-1:0]  k, kp1;
  logic [bfa_pkg::CW-1:0]  counts [bfa_pkg::ORDERS];
  logic [bfa_pkg::FRAMES-1:0] owned, blk;
  logic                    seeded, seed_rd;

  // input decode
  logic [bfa_pkg::OW-1:0]  ord_in;
  logic                    ok_in, hit;
  logic [bfa_pkg::FW-1:0]  s_in, mask_in;

  // ram
  logic                    rd_en, wr_en;
  logic [bfa_pkg::AW-1:0]  rd_addr, wr_addr;
  logic [bfa_pkg::FW-1:0]  wr_data, rdata, rdata_eff;

  always_comb begin
    ord_in = '0;
    ok_in  = 1'b0;
    for (int i = bfa_pkg::ORDERS - 1; i >= 0; i--) begin
      if ((32'd1 << i) >= 32'(block_size)) begin
        ord_in = bfa_pkg::OW'(i);
        ok_in  = 1'b1;
      end
    end
    if (block_size == '0 || 32'(block_size) > bfa_pkg::FRAMES) begin
      ok_in = 1'b0;
    end
    mask_in = bfa_pkg::FW'((32'd1 << ord_in) - 32'd1);
    s_in    = free_start & ~mask_in;
  end

  assign mask  = bfa_pkg::FW'((32'd1 << ord_q) - 32'd1);
  assign on    = o - 1'b1;
  assign kp1   = k + 1'b1;
  assign buddy = s ^ bfa_pkg::FW'(32'd1 << o);

  always_comb begin
    for (int j = 0; j < bfa_pkg::FRAMES; j++) begin
      blk[j] = ((bfa_pkg::FW'(j) & ~mask) == s);
    end
  end

  // lowest nonempty order at or above the wanted one
  always_comb begin
    fo  = '0;
    hit = 1'b0;
    for (int i = 0; i < bfa_pkg::ORDERS; i++) begin
      if (!hit && bfa_pkg::OW'(i) >= ord_q && counts[i] != '0) begin
        fo  = bfa_pkg::OW'(i);
        hit = 1'b1;
      end
    end
  end

  assign rdata_eff = seed_rd ? '0 : rdata;

  always_comb begin
    rd_en   = cmd.front_rd | cmd.sh_rd | cmd.scan_rd;
    rd_addr = {o, k[bfa_pkg::FW-1:0]};
    if (cmd.front_rd) begin
      rd_addr = {fo, {bfa_pkg::FW{1'b0}}};
    end else if (cmd.sh_rd) begin
      rd_addr = {o, kp1[bfa_pkg::FW-1:0]};
    end
    wr_en   = 1'b0;
    wr_addr = {o, k[bfa_pkg::FW-1:0]};
    wr_data = rdata_eff;
    if (cmd.sh_wr) begin
      wr_en = 1'b1;
    end else if (cmd.split) begin
      wr_en   = counts[on] < bfa_pkg::CW'(bfa_pkg::SPAN);
      wr_addr = {on, counts[on][bfa_pkg::FW-1:0]};
      wr_data = s + bfa_pkg::FW'(32'd1 << on);
    end else if (cmd.push) begin
      wr_en   = counts[o] < bfa_pkg::CW'(bfa_pkg::SPAN);
      wr_addr = {o, counts[o][bfa_pkg::FW-1:0]};
      wr_data = s;
    end
  end

  bfa_ram #(
    .WIDTH (bfa_pkg::FW),
    .DEPTH (1 << bfa_pkg::AW)
  ) u_lists (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_free <= req_type;
      bad_q    <= ~ok_in;
      prior_en <= has_prior_id;
      prior_q  <= prior_id;
      ord_q    <= ord_in;
      s        <= s_in;
    end
    if (cmd.front_rd) begin
      o <= fo;
    end
    if (cmd.take_front) begin
      s <= rdata_eff;
      k <= '0;
    end
    if (cmd.sh_wr || cmd.scan_next) begin
      k <= kp1;
    end
    if (cmd.split) begin
      o <= on;
    end
    if (cmd.merge) begin
      s <= s & ~bfa_pkg::FW'(32'd1 << o);
      o <= o + 1'b1;
      k <= '0;
    end
    if (cmd.free_clear) begin
      o <= ord_q;
      k <= '0;
    end
    if (cmd.alloc_fin) begin
      id_q <= prior_en ? prior_q : next_id;
    end
    if (cmd.result) begin
      if (cmd.code == bfa_pkg::ST_DONE && !req_free) begin
        start_frame <= s;
        block_order <= ord_q;
        alloc_id    <= id_q;
      end else begin
        start_frame <= '0;
        block_order <= '0;
        alloc_id    <= '0;
      end
      status <= cmd.code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bfa_pkg::ORDERS; i++) begin
        counts[i] <= (i == bfa_pkg::ORDERS - 1) ? bfa_pkg::CW'(1) : '0;
      end
      owned     <= '0;
      next_id   <= '0;
      seeded    <= 1'b0;
      seed_rd   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // the top list starts holding frame 0 before its entry is ever written
      if (rd_en) begin
        seed_rd <= !seeded && rd_addr == {TOP, {bfa_pkg::FW{1'b0}}};
      end
      if (wr_en && wr_addr == {TOP, {bfa_pkg::FW{1'b0}}}) begin
        seeded <= 1'b1;
      end
      if (cmd.sh_end) begin
        counts[o] <= counts[o] - 1'b1;
      end
      if (cmd.split && counts[on] < bfa_pkg::CW'(bfa_pkg::SPAN)) begin
        counts[on] <= counts[on] + 1'b1;
      end
      if (cmd.push && counts[o] < bfa_pkg::CW'(bfa_pkg::SPAN)) begin
        counts[o] <= counts[o] + 1'b1;
      end
      if (cmd.free_clear) begin
        owned <= owned & ~blk;
      end
      if (cmd.alloc_fin) begin
        owned <= owned | blk;
        if (!prior_en) begin
          next_id <= next_id + 1'b1;
        end
      end
      if (cmd.result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.req_free   = req_free;
    sts.bad        = bad_q;
    sts.no_space   = ~hit;
    sts.not_owned  = |(blk & ~owned);
    sts.o_gt_ord   = o > ord_q;
    sts.shift_last = kp1 >= counts[o];
    sts.scan_end   = k >= counts[o];
    sts.match      = rdata_eff == buddy;
    sts.top        = o == TOP;
    sts.out_free   = ~out_valid | out_ready;
  end

endmodule

`default_nettype wire

/* hw/rtl/bfa_ctrl.sv */
// bfa_ctrl: sequencing state machine of the buddy frame allocator.
// Uses bfa_pkg; drives the datapath through cmd_t, watches sts_t.
`default_nettype none

module bfa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bfa_pkg::sts_t sts,
  output bfa_pkg::cmd_t cmd
);

  typedef enum logic [10:0] {
    S_IDLE       = 11'b00000000001,
    S_DECODE     = 11'b00000000010,
    S_FRONT_WAIT = 11'b00000000100,
    S_SH_CHK     = 11'b00000001000,
    S_SH_WR      = 11'b00000010000,
    S_SPLIT      = 11'b00000100000,
    S_MERGE      = 11'b00001000000,
    S_SCAN_CHK   = 11'b00010000000,
    S_SCAN_CMP   = 11'b00100000000,
    S_PUSH       = 11'b01000000000,
    S_RESULT     = 11'b10000000000
  } state_t;

  state_t           state, state_next;
  bfa_pkg::status_t code, code_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    code_next  = code;
    cmd        = '0;
    cmd.code   = code;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.bad) begin
          code_next  = bfa_pkg::ST_BAD;
          state_next = S_RESULT;
        end else if (!sts.req_free) begin
          if (sts.no_space) begin
            code_next  = bfa_pkg::ST_NO_SPACE;
            state_next = S_RESULT;
          end else begin
            cmd.front_rd = 1'b1;
            state_next   = S_FRONT_WAIT;
          end
        end else if (sts.not_owned) begin
          code_next  = bfa_pkg::ST_BAD;
          state_next = S_RESULT;
        end else begin
          cmd.free_clear = 1'b1;
          state_next     = S_SCAN_CHK;
        end
      end
      S_FRONT_WAIT: begin
        cmd.take_front = 1'b1;
        state_next     = S_SH_CHK;
      end
      S_SH_CHK: begin
        if (sts.shift_last) begin
          cmd.sh_end = 1'b1;
          state_next = sts.req_free ? S_MERGE : S_SPLIT;
        end else begin
          cmd.sh_rd  = 1'b1;
          state_next = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.sh_wr  = 1'b1;
        state_next = S_SH_CHK;
      end
      S_SPLIT: begin
        if (sts.o_gt_ord) begin
          cmd.split = 1'b1;
        end else begin
          cmd.alloc_fin = 1'b1;
          code_next     = bfa_pkg::ST_DONE;
          state_next    = S_RESULT;
        end
      end
      S_MERGE: begin
        cmd.merge  = 1'b1;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts.top || sts.scan_end) begin
          state_next = S_PUSH;
        end else begin
          cmd.scan_rd = 1'b1;
          state_next  = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (sts.match) begin
          state_next = S_SH_CHK;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = S_SCAN_CHK;
        end
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        code_next  = bfa_pkg::ST_DONE;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.result = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= bfa_pkg::ST_DONE;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/buddy_frame_allocator.sv */
// buddy_frame_allocator: top level, stream ports around controller and datapath.
// Uses bfa_pkg, bfa_ctrl, bfa_datapath.
`default_nettype none

// Buddy allocator over 64 frames in orders 0 to 6, one request at a time, one
// result word per request. A rejected or no-space request goes from decode
// straight to the result. An allocation takes the front of the lowest nonempty
// list that fits, shifts the entries left behind it down the list and splits
// down to the wanted order. A free compares the entries in each order it
// searches, and for each merge shifts out the entries behind the buddy. All list
// work goes through the free list ram, one write port and one registered read.
// A finished result waits in the output register while the next request enters;
// a request stalls at its end only while that register still holds a word.
module buddy_frame_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // block_size[6:0], free_start[12:7], has_prior_id[13], prior_id[29:14], zero
  input  logic [31:0] s_axis_tdata,
  // req_type
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // start_frame[5:0], block_order[8:6], alloc_id[24:9], zero
  output logic [31:0] m_axis_tdata,
  // status
  output logic [1:0]  m_axis_tuser
);

  bfa_pkg::cmd_t            cmd;
  bfa_pkg::sts_t            sts;
  logic [bfa_pkg::FW-1:0]   start_frame;
  logic [bfa_pkg::OW-1:0]   block_order;
  logic [bfa_pkg::IDW-1:0]  alloc_id;

  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfa_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .req_type     (s_axis_tuser),
    .block_size   (s_axis_tdata[6:0]),
    .free_start   (s_axis_tdata[12:7]),
    .has_prior_id (s_axis_tdata[13]),
    .prior_id     (s_axis_tdata[29:14]),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .start_frame  (start_frame),
    .block_order  (block_order),
    .alloc_id     (alloc_id),
    .status       (m_axis_tuser)
  );

  assign m_axis_tdata = {7'd0, alloc_id, block_order, start_frame};

endmodule

`default_nettype wire
